>>> src/ror_pkg.sv
// Shared types and constants for the range outlier rejection block.
package ror_pkg;

  localparam int unsigned RangeW = 16;
  localparam int unsigned TickW  = 10;
  localparam int unsigned LimitW = 15;
  localparam int unsigned RunW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [TickW-1:0]  TickReset     = 10'd8;
  localparam logic [TickW-1:0]  IntervalReset = 10'd14;
  localparam logic [LimitW-1:0] LimitReset    = 15'd500;
  localparam logic [RunW-1:0]   MaxRunReset   = 4'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECIM_INTERVAL  = 2'd0,
    CFG_JUMP_LIMIT      = 2'd1,
    CFG_MAX_CONSECUTIVE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TickW-1:0]  decim_interval;
    logic [LimitW-1:0] jump_limit;
    logic [RunW-1:0]   max_consecutive;
  } cfg_t;

  typedef struct packed {
    logic        [TickW-1:0]  tick_count;
    logic signed [RangeW-1:0] held_range;
    logic signed [RangeW-1:0] hist0;
    logic signed [RangeW-1:0] hist1;
    logic signed [RangeW-1:0] hist2;
    logic        [RunW-1:0]   outlier_run;
  } state_t;

  typedef struct packed {
    logic signed [RangeW-1:0] range_out;
    logic                     sample_taken;
    logic                     replaced;
  } result_t;

endpackage

>>> src/ror_if.sv
// Valid/ready channel interfaces for the input readings and the cleaned results.
interface ror_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] raw_range;

  modport source (output valid, output raw_range, input ready);
  modport sink   (input valid, input raw_range, output ready);
endinterface

interface ror_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] range_out;
  logic               sample_taken;
  logic               replaced;

  modport source (output valid, output range_out, output sample_taken, output replaced,
                  input ready);
  modport sink   (input valid, input range_out, input sample_taken, input replaced,
                  output ready);
endinterface

>>> src/range_outlier_rejection.sv
// Range outlier rejection top level: one cleaned result for every input transaction.
// One transaction is taken every cycle when the result side keeps up. A reading is
// first captured in an input register; the decision logic then updates the filter state
// and loads the result register, which presents the result. The result register holds
// while the consumer stalls, and the input register keeps taking a new reading as long
// as the result register is free or being emptied in the same cycle. Configuration
// writes take effect on the next edge.
module range_outlier_rejection (
  input  logic                               clk,
  input  logic                               rst_n,
  ror_in_if.sink                             in_ch,
  ror_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ror_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [ror_pkg::CfgDataW-1:0]       cfg_wdata
);

  ror_pkg::cfg_t    cfg_r;
  ror_pkg::state_t  state_r;
  ror_pkg::state_t  state_nxt;
  ror_pkg::result_t res_nxt;
  ror_pkg::result_t res_r;

  logic               s1_valid_r;
  logic signed [15:0] s1_raw_r;
  logic               out_valid_r;
  logic               adv;
  logic               in_take;

  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready         = !s1_valid_r || adv;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.range_out    = res_r.range_out;
  assign out_ch.sample_taken = res_r.sample_taken;
  assign out_ch.replaced     = res_r.replaced;

  ror_judge u_judge (
    .cur       (state_r),
    .cfg       (cfg_r),
    .raw_range (s1_raw_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decim_interval  <= ror_pkg::IntervalReset;
      cfg_r.jump_limit      <= ror_pkg::LimitReset;
      cfg_r.max_consecutive <= ror_pkg::MaxRunReset;
    end else if (cfg_we) begin
      case (cfg_index)
        ror_pkg::CFG_DECIM_INTERVAL:
          cfg_r.decim_interval <= cfg_wdata[ror_pkg::TickW-1:0];
        ror_pkg::CFG_JUMP_LIMIT:
          cfg_r.jump_limit <= cfg_wdata[ror_pkg::LimitW-1:0];
        ror_pkg::CFG_MAX_CONSECUTIVE:
          cfg_r.max_consecutive <= cfg_wdata[ror_pkg::RunW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.tick_count  <= ror_pkg::TickReset;
      state_r.held_range  <= '0;
      state_r.hist0       <= '0;
      state_r.hist1       <= '0;
      state_r.hist2       <= '0;
      state_r.outlier_run <= '0;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (adv) begin
        state_r <= state_nxt;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r <= in_ch.raw_range;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  a_no_input_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_take && s1_valid_r && !adv))
    else $error("Input register overwritten while still holding a reading.");

  a_sample_clears_tick: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.sample_taken |=> state_r.tick_count == '0)
    else $error("Tick count not restarted after a sample.");

  a_replace_counts_run: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.replaced |=> state_r.outlier_run != '0)
    else $error("Replacement not counted in the outlier run.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_r))
    else $error("Stalled result changed before it was taken.");

endmodule

>>> src/ror_judge.sv
// Per-tick decision: decimation, outlier test, extrapolation and history update.
module ror_judge (
  input  ror_pkg::state_t          cur,
  input  ror_pkg::cfg_t            cfg,
  input  logic signed [15:0]       raw_range,
  output ror_pkg::state_t          nxt,
  output ror_pkg::result_t         res
);

  always_comb begin
    logic signed [15:0] jump;
    logic signed [16:0] jump_x;
    logic signed [16:0] lim_x;
    logic signed [16:0] diff;
    logic signed [16:0] half;
    logic signed [16:0] extrap;
    logic               outlier;

    jump    = raw_range - cur.hist0;
    jump_x  = {jump[15], jump};
    lim_x   = {2'b00, cfg.jump_limit};
    outlier = (cur.outlier_run < cfg.max_consecutive) &&
              ((jump_x > lim_x) || (jump_x < -lim_x));
    diff    = {cur.hist0[15], cur.hist0} - {cur.hist2[15], cur.hist2};
    half    = (diff + $signed({16'd0, diff[16]})) >>> 1;
    extrap  = {cur.hist0[15], cur.hist0} + half;

    nxt              = cur;
    res.sample_taken = 1'b0;
    res.replaced     = 1'b0;

    if (cur.tick_count > cfg.decim_interval) begin
      nxt.tick_count   = '0;
      res.sample_taken = 1'b1;
      if (raw_range > 16'sd0) begin
        if (outlier) begin
          nxt.held_range  = extrap[15:0];
          nxt.outlier_run = cur.outlier_run + 4'd1;
          res.replaced    = 1'b1;
        end else begin
          nxt.held_range  = raw_range;
          nxt.outlier_run = '0;
          nxt.hist2       = cur.hist1;
          nxt.hist1       = cur.hist0;
          nxt.hist0       = raw_range;
        end
      end
    end else begin
      nxt.tick_count = cur.tick_count + 10'd1;
    end

    res.range_out = nxt.held_range;
  end

endmodule

>>> tb/sv/range_outlier_rejection_checker.sv
// Checker that predicts each cleaned range result and compares it with the block's output.
module range_outlier_rejection_checker
  import ror_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ror_in_if                   in_ch,
  ror_out_if                  out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen,
  output int                  replacements_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t    filter_cfg;
  state_t  filter_st;
  result_t expected_q[$];
  int      fails;
  int      results;
  int      repl_count;

  function automatic result_t filter_step(input logic signed [RangeW-1:0] raw);
    result_t                  r;
    logic signed [RangeW-1:0] jump;
    int                       lim;
    int                       trend;
    r = '0;
    if (filter_st.tick_count > filter_cfg.decim_interval) begin
      filter_st.tick_count = '0;
      r.sample_taken = 1'b1;
      if (raw > 0) begin
        jump = raw - filter_st.hist0;
        lim = int'(filter_cfg.jump_limit);
        if (filter_st.outlier_run < filter_cfg.max_consecutive &&
            (int'(jump) > lim || int'(jump) < -lim)) begin
          // A spike is replaced by continuing the trend of the last three good values.
          trend = int'(filter_st.hist0) - int'(filter_st.hist2);
          filter_st.held_range = RangeW'(int'(filter_st.hist0) + trend / 2);
          filter_st.outlier_run = filter_st.outlier_run + 1'b1;
          r.replaced = 1'b1;
        end else begin
          filter_st.held_range = raw;
          filter_st.outlier_run = '0;
          filter_st.hist2 = filter_st.hist1;
          filter_st.hist1 = filter_st.hist0;
          filter_st.hist0 = raw;
        end
      end
    end else begin
      filter_st.tick_count = filter_st.tick_count + 1'b1;
    end
    r.range_out = filter_st.held_range;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      filter_cfg.decim_interval = IntervalReset;
      filter_cfg.jump_limit = LimitReset;
      filter_cfg.max_consecutive = MaxRunReset;
      filter_st = '0;
      filter_st.tick_count = TickReset;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.range_out = out_ch.range_out;
        got.sample_taken = out_ch.sample_taken;
        got.replaced = out_ch.replaced;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected: range_out %0d sample_taken %0b replaced %0b",
                   $time, got.range_out, got.sample_taken, got.replaced);
        end else begin
          want = expected_q.pop_front();
          results++;
          if (want.replaced) repl_count++;
          if (got.range_out !== want.range_out) begin
            fails++;
            $display("%0t: range_out expected %0d actual %0d",
                     $time, want.range_out, got.range_out);
          end
          if (got.sample_taken !== want.sample_taken) begin
            fails++;
            $display("%0t: sample_taken expected %0b actual %0b",
                     $time, want.sample_taken, got.sample_taken);
          end
          if (got.replaced !== want.replaced) begin
            fails++;
            $display("%0t: replaced expected %0b actual %0b",
                     $time, want.replaced, got.replaced);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(filter_step(in_ch.raw_range));
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DECIM_INTERVAL:  filter_cfg.decim_interval = cfg_wdata[TickW-1:0];
          CFG_JUMP_LIMIT:      filter_cfg.jump_limit = cfg_wdata[LimitW-1:0];
          CFG_MAX_CONSECUTIVE: filter_cfg.max_consecutive = cfg_wdata[RunW-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending <= expected_q.size();
    results_seen <= results;
    replacements_seen <= repl_count;
  end

endmodule

>>> tb/sv/range_outlier_rejection_tb.sv
// Top-level testbench that drives readings and register settings into the range outlier block.
module range_outlier_rejection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ror_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 80;
  localparam logic signed [RangeW-1:0] DirectedReadings [12] = '{
    16'sd100, 16'sd400, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd1,
    -16'sd1, 16'sd0, -16'sd32768, 16'sd32766, 16'sd32767, 16'sd1
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int results_seen;
  int replacements_seen;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  int readings_sent;
  int settings_used;
  int quiet_cycles;
  int level;

  ror_in_if  in_ch();
  ror_out_if out_ch();

  always #10 clk = ~clk;

  range_outlier_rejection u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  range_outlier_rejection_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_seen      (results_seen),
    .replacements_seen (replacements_seen)
  );

  task automatic send_reading(input logic signed [RangeW-1:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_range <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    readings_sent++;
  endtask

  task automatic write_settings(input logic [TickW-1:0] interval, input logic [LimitW-1:0] limit,
                                input logic [RunW-1:0] max_run);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DECIM_INTERVAL;
    cfg_wdata <= CfgDataW'(interval);
    @(posedge clk);
    cfg_index <= CFG_JUMP_LIMIT;
    cfg_wdata <= CfgDataW'(limit);
    @(posedge clk);
    cfg_index <= CFG_MAX_CONSECUTIVE;
    cfg_wdata <= CfgDataW'(max_run);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly a smooth trace around a drifting level, with spikes, dropouts and noise mixed in.
  function automatic logic signed [RangeW-1:0] next_reading(input int spread);
    int pick;
    int step;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if (pick < 3) level = $urandom_range(1, 32767);
      step = int'($urandom_range(0, 2 * spread)) - spread;
      level = level + step;
      if (level < 1) level = 1;
      if (level > 32767) level = 32767;
      return RangeW'(level);
    end else if (pick < 82) begin
      step = int'($urandom_range(spread, 20000));
      return RangeW'($urandom_range(0, 1) ? level + step : level - step);
    end else if (pick < 90) begin
      return RangeW'(-int'($urandom_range(0, 32768)));
    end
    return RangeW'($urandom);
  endfunction

  task automatic run_phase(input logic [TickW-1:0] interval, input logic [LimitW-1:0] limit,
                           input logic [RunW-1:0] max_run, input int count, input int spread);
    write_settings(interval, limit, max_run);
    repeat (count) send_reading(next_reading(spread));
    wait_drained();
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        recv_hold = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timed out after %0d cycles without a transaction.", QuietLimit);
    $display("range_outlier_rejection_tb failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.raw_range <= '0;
    send_idle_pct = 37;
    recv_idle_pct = 67;
    recv_hold = 1'b0;
    readings_sent = 0;
    settings_used = 0;
    level = 1000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the shortest interval every other tick samples, so each value is sent twice.
    write_settings(10'd0, 15'd500, 4'd2);
    foreach (DirectedReadings[i]) begin
      send_reading(DirectedReadings[i]);
      send_reading(DirectedReadings[i]);
    end
    wait_drained();

    run_phase(10'd1023, 15'd32767, 4'd15, 40, 300);
    run_phase(10'd0, 15'd0, 4'd0, 60, 200);
    run_phase(10'd3, 15'd200, 4'd3, 300, 150);

    send_idle_pct = 67;
    recv_idle_pct = 37;
    run_phase(10'd1, 15'd50, 4'd1, 300, 40);
    run_phase(10'd2, 15'd32767, 4'd15, 250, 3000);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    run_phase(10'd0, 15'd1000, 4'd4, 300, 700);
    run_phase(IntervalReset, LimitReset, MaxRunReset, 150, 400);
    run_phase(10'd5, LimitW'($urandom_range(0, 32767)), RunW'($urandom_range(0, 15)), 130, 500);

    $display("Sent %0d readings under %0d register settings, including directed extremes.",
             readings_sent, settings_used);
    $display("Checked %0d results, %0d of them spikes replaced by extrapolation.",
             results_seen, replacements_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("range_outlier_rejection_tb passed");
    end else begin
      $display("range_outlier_rejection_tb failed");
    end
    $finish;
  end

endmodule

>>> range_outlier_rejection.f
src/ror_pkg.sv
src/ror_if.sv
src/ror_judge.sv
src/range_outlier_rejection.sv
tb/sv/range_outlier_rejection_checker.sv
tb/sv/range_outlier_rejection_tb.sv
